// ===== sv/rfch_pkg.sv =====
// ----------------------------------------------------------------------------
// rfch_pkg
// Types and constants shared by the radio frame classifier histogram blocks.
// ----------------------------------------------------------------------------
package rfch_pkg;

  // request types
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // frame classes
  localparam logic [1:0] CLS_FOREIGN  = 2'd0;
  localparam logic [1:0] CLS_OURS     = 2'd1;
  localparam logic [1:0] CLS_OURS_BAD = 2'd2;
  localparam logic [1:0] CLS_NOISE    = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEVNUM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEV_TYPE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TX_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_TABLE    = 3'd3;

  // configuration reset values
  localparam logic [15:0] RST_TARGET_DEVNUM   = 16'd14871;
  localparam logic [6:0]  RST_TARGET_DEV_TYPE = 7'h0B;
  localparam logic [7:0]  RST_TARGET_TX_TYPE  = 8'h05;
  localparam logic [63:0] RST_PREFIX_TABLE    = 64'h8877_1755_4433_2211;

  // histogram geometry
  localparam int unsigned HIST_DEPTH  = 256;
  localparam int unsigned HIST_ADDR_W = 8;

  typedef struct packed {
    logic        req_type;
    logic        crc_ok;
    logic [2:0]  match_slot;
    logic [7:0]  dev_hi;
    logic [7:0]  dev_type;
    logic [7:0]  tx_type;
    logic [7:0]  ctrl_byte;
    logic [31:0] frame_time;
    logic [7:0]  hist_bin;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         frame_class;
    logic               odd_type;
    logic [15:0]        device_number;
    logic signed [31:0] time_delta;
    logic [31:0]        hist_count;
    logic [31:0]        count_ours;
    logic [31:0]        count_foreign;
    logic [31:0]        count_longframe;
    logic [31:0]        count_oddtype;
  } out_item_t;

  typedef struct packed {
    logic [15:0] target_devnum;
    logic [6:0]  target_dev_type;
    logic [7:0]  target_tx_type;
    logic [63:0] prefix_table;
  } cfg_regs_t;

  // histogram access issued with an accepted item
  typedef struct packed {
    logic                   is_read;
    logic                   inc;
    logic [HIST_ADDR_W-1:0] addr;
  } hist_req_t;

endpackage

// ===== sv/rfch_classify.sv =====
// ----------------------------------------------------------------------------
// rfch_classify
// Rebuilds the device number, classes the frame, keeps the scalar counters
// and the last timestamp of ours, and issues the histogram access.
// ----------------------------------------------------------------------------
module rfch_classify import rfch_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_regs_t cfg,
  input  logic      accept,
  input  in_item_t  in_data,
  output out_item_t res,
  output hist_req_t hreq
);

  logic [COUNTER_WIDTH-1:0] ours_cnt_r, ours_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] foreign_cnt_r, foreign_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] long_cnt_r, long_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] odd_cnt_r, odd_cnt_nxt;
  logic [31:0]              last_time_r, last_time_nxt;
  logic                     seen_r, seen_nxt;

  logic [7:0]  dev_lo;
  logic [15:0] dev_num;
  logic        ours;
  logic        typical;

  function automatic logic [31:0] low32(input logic [63:0] v);
    return v[31:0];
  endfunction

  // device number and type checks
  always_comb begin
    dev_lo  = cfg.prefix_table[{in_data.match_slot, 3'b000} +: 8];
    dev_num = {in_data.dev_hi, dev_lo};
    ours    = (dev_num == cfg.target_devnum);
    typical = (in_data.dev_type[6:0] == cfg.target_dev_type) &&
              (in_data.tx_type == cfg.target_tx_type);
  end

  // classification, counter updates and result fields
  always_comb begin
    ours_cnt_nxt    = ours_cnt_r;
    foreign_cnt_nxt = foreign_cnt_r;
    long_cnt_nxt    = long_cnt_r;
    odd_cnt_nxt     = odd_cnt_r;
    last_time_nxt   = last_time_r;
    seen_nxt        = seen_r;
    res             = '0;
    hreq.is_read    = (in_data.req_type == REQ_READ);
    hreq.inc        = 1'b0;
    hreq.addr       = in_data.ctrl_byte;

    if (in_data.req_type == REQ_READ) begin
      hreq.addr = in_data.hist_bin;
    end else begin
      res.device_number = dev_num;
      if (!ours) begin
        if (in_data.crc_ok) begin
          res.frame_class = CLS_FOREIGN;
          foreign_cnt_nxt = foreign_cnt_r + 1'b1;
        end else begin
          res.frame_class = CLS_NOISE;
        end
      end else begin
        if (in_data.crc_ok) begin
          res.frame_class = CLS_OURS;
          ours_cnt_nxt    = ours_cnt_r + 1'b1;
          hreq.inc        = 1'b1;
          if (!typical) begin
            odd_cnt_nxt = odd_cnt_r + 1'b1;
          end
        end else begin
          res.frame_class = CLS_OURS_BAD;
          long_cnt_nxt    = long_cnt_r + 1'b1;
        end
        res.odd_type   = !typical;
        res.time_delta = seen_r ? $signed(in_data.frame_time - last_time_r) : '0;
        last_time_nxt  = in_data.frame_time;
        seen_nxt       = 1'b1;
      end
    end

    res.count_ours      = low32(64'(ours_cnt_nxt));
    res.count_foreign   = low32(64'(foreign_cnt_nxt));
    res.count_longframe = low32(64'(long_cnt_nxt));
    res.count_oddtype   = low32(64'(odd_cnt_nxt));
  end

  // scalar state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ours_cnt_r    <= '0;
      foreign_cnt_r <= '0;
      long_cnt_r    <= '0;
      odd_cnt_r     <= '0;
      last_time_r   <= '0;
      seen_r        <= 1'b0;
    end else if (accept) begin
      ours_cnt_r    <= ours_cnt_nxt;
      foreign_cnt_r <= foreign_cnt_nxt;
      long_cnt_r    <= long_cnt_nxt;
      odd_cnt_r     <= odd_cnt_nxt;
      last_time_r   <= last_time_nxt;
      seen_r        <= seen_nxt;
    end
  end

endmodule

// ===== sv/rfch_hist.sv =====
// ----------------------------------------------------------------------------
// rfch_hist
// Control-byte histogram: one synchronous memory with per-bin valid bits,
// read at issue, incremented and written back at retire, with forwarding.
// ----------------------------------------------------------------------------
module rfch_hist import rfch_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        issue,
  input  hist_req_t   hreq,
  input  logic        retire,
  output logic [31:0] hist_count
);

  logic [COUNTER_WIDTH-1:0] mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]    bin_vld_r;

  logic [COUNTER_WIDTH-1:0] rdata_r;
  logic                     rvld_r;
  logic                     fwd_r;
  logic [COUNTER_WIDTH-1:0] fwd_data_r;
  hist_req_t                req_r;

  logic                     wr_en;
  logic [COUNTER_WIDTH-1:0] cur;
  logic [COUNTER_WIDTH-1:0] wr_data;
  logic [63:0]              cur_ext;

  // current bin value, newest write first
  always_comb begin
    if (fwd_r) begin
      cur = fwd_data_r;
    end else if (rvld_r) begin
      cur = rdata_r;
    end else begin
      cur = '0;
    end
    wr_en      = retire && req_r.inc;
    wr_data    = cur + 1'b1;
    cur_ext    = 64'(cur);
    hist_count = req_r.is_read ? cur_ext[31:0] : 32'd0;
  end

  // bin storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[req_r.addr] <= wr_data;
    end
    if (issue) begin
      rdata_r <= mem[hreq.addr];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
    end else if (wr_en) begin
      bin_vld_r[req_r.addr] <= 1'b1;
    end
  end

  // request held with its read data, forwarding of a same-edge write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
      fwd_r <= 1'b0;
    end else if (issue) begin
      req_r <= hreq;
      fwd_r <= wr_en && (req_r.addr == hreq.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rvld_r     <= bin_vld_r[hreq.addr];
      fwd_data_r <= wr_data;
    end
  end

endmodule

// ===== sv/radio_frame_classifier_histogram.sv =====
// ----------------------------------------------------------------------------
// radio_frame_classifier_histogram
// Classifies radio frame headers, counts frame classes and keeps a
// control-byte histogram that can be read back one bin at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one request item: a frame header to
//   classify or a histogram bin read. out_valid/out_stall/out_data return
//   exactly one result item per request, in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the four setup registers;
//   cfg_ready is always high, unknown indexes are ignored.
//   out_valid rises after an accepted item passes the middle stage and then
//   the output register. One item per cycle is sustained while out_stall is
//   low: the histogram bin is read the cycle an item is accepted and written
//   back the cycle it moves to the output register; a new item hitting the
//   same bin takes the written value by forwarding.
//   Reset clears all counters, the timestamp history and the histogram
//   (through per-bin valid bits, no clearing pass) and restores the setup
//   registers to their defaults.
//   While out_stall holds a result, one more item is taken into the middle
//   stage, then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module radio_frame_classifier_histogram import rfch_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cfg_regs_t cfg_r;
  logic      in_acc;
  logic      s1_adv;
  logic      s1_valid_r;
  out_item_t s1_res_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  out_item_t cls_res;
  hist_req_t hreq;
  logic [31:0] hist_count;

  // handshake
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // setup registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_devnum   <= RST_TARGET_DEVNUM;
      cfg_r.target_dev_type <= RST_TARGET_DEV_TYPE;
      cfg_r.target_tx_type  <= RST_TARGET_TX_TYPE;
      cfg_r.prefix_table    <= RST_PREFIX_TABLE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_DEVNUM:   cfg_r.target_devnum   <= cfg_data[15:0];
        CFG_TARGET_DEV_TYPE: cfg_r.target_dev_type <= cfg_data[6:0];
        CFG_TARGET_TX_TYPE:  cfg_r.target_tx_type  <= cfg_data[7:0];
        CFG_PREFIX_TABLE:    cfg_r.prefix_table    <= cfg_data;
        default: ;
      endcase
    end
  end

  // classification and counters
  rfch_classify #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_classify (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (in_acc),
    .in_data(in_data),
    .res    (cls_res),
    .hreq   (hreq)
  );

  // histogram memory
  rfch_hist #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (in_acc),
    .hreq      (hreq),
    .retire    (s1_valid_r && s1_adv),
    .hist_count(hist_count)
  );

  // middle stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // middle stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r <= cls_res;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // result with the histogram count merged in
  always_comb begin
    out_data_nxt            = s1_res_r;
    out_data_nxt.hist_count = hist_count;
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("item accepted while both stages are held");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item lost before the middle stage");

  a_read_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.req_type == REQ_READ) |=>
      (s1_res_r.time_delta == 32'sd0 && s1_res_r.device_number == 16'd0 &&
       s1_res_r.frame_class == CLS_FOREIGN))
    else $error("read request carries frame fields");

  a_frame_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.frame_class != CLS_FOREIGN) |->
      out_data_r.hist_count == 32'd0)
    else $error("frame result carries a histogram count");

endmodule
